// ===== rtl/prc_pkg.sv =====
// shared constants and types for the partition table block
package prc_pkg;
  localparam int PARTITIONS_DEF = 8;
  localparam int STORE_BYTES_DEF = 1024;
  localparam logic [1:0] CMD_RESIZE = 2'd0;
  localparam logic [1:0] CMD_TRANSLATE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_VIOLATION = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic REG_MEMORY_SIZE = 1'b0;
  localparam logic REG_DATA_START = 1'b1;

  typedef struct packed {
    logic [10:0] start;
    logic [10:0] size;
    logic [10:0] count;
  } part_t;
endpackage

// ===== rtl/partition_resize_with_compaction.sv =====
// top level: partition table, command sequencer and byte mover
// A translate is answered from the state that accepts it; a byte read or write goes
// through S_BYTE (one registered store read plus the result register). A resize walks
// the partition table one entry a cycle, passes a decision state, then moves each byte
// of the later partitions with one store read and one store write through the single
// store port pair, and then updates the table. When the total is unchanged or the store
// is full, the result is given from the decision state with no move. After reset a clearing
// pass erases the store to 0xFF; no transaction is taken during it, configuration writes
// are taken as ever.
module partition_resize_with_compaction #(
  parameter int PARTITIONS = prc_pkg::PARTITIONS_DEF,
  parameter int STORE_BYTES = prc_pkg::STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [3:0]  partition_id,
  input  logic [10:0] new_size,
  input  logic [10:0] new_count,
  input  logic [9:0]  item_index,
  input  logic [9:0]  byte_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] address,
  output logic [7:0]  read_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DECIDE = 3'd2,
    S_RD = 3'd3, S_WR = 3'd4, S_FIX = 3'd5, S_DONE = 3'd6, S_BYTE = 3'd7;

  prc_pkg::part_t tab [PARTITIONS];
  logic [10:0] memory_size;
  logic [9:0]  data_start;
  logic [2:0]  state;
  logic [1:0]  cmd;
  logic [PW-1:0] id;
  logic [10:0] nsize, ncount;
  logic [9:0]  baddr;
  logic [7:0]  wdata;
  logic [PW:0] scan;
  logic [22:0] old_total, new_total;
  logic [23:0] start;
  logic        later;
  logic [23:0] move_lo, move_hi;
  logic signed [25:0] shift, a;
  logic [7:0] rd_byte;
  logic clearing;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [7:0] wr_data;
  logic id_bad;
  logic [22:0] scan_total;
  logic scan_active;
  prc_pkg::part_t scan_e;
  logic signed [25:0] dst;
  logic src_ok, dst_ok;
  logic [1:0]  acc_status;
  logic [15:0] acc_address;

  prc_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk, .rst, .rd_addr, .rd_data(rd_byte), .wr_en, .wr_addr, .wr_data, .clearing
  );

  assign in_stall = state != S_IDLE || out_valid || clearing;
  assign id_bad = 32'(partition_id) >= PARTITIONS;
  assign scan_e = tab[scan[PW-1:0]];
  assign scan_total = scan_e.size * scan_e.count;
  assign scan_active = scan_e.size != 11'd0 && scan_e.count != 11'd0;
  assign dst = a + shift;
  assign src_ok = a >= 0 && a < STORE_BYTES;
  assign dst_ok = dst >= 0 && dst < STORE_BYTES;

  // status and address of a transaction as it is accepted
  always_comb begin
    acc_status = prc_pkg::ST_OK;
    acc_address = '0;
    if (command == prc_pkg::CMD_RESIZE || command == prc_pkg::CMD_TRANSLATE) begin
      if (id_bad) begin
        acc_status = prc_pkg::ST_VIOLATION;
      end else if (command == prc_pkg::CMD_TRANSLATE) begin
        acc_address = 16'(tab[partition_id[PW-1:0]].start +
          item_index * tab[partition_id[PW-1:0]].size);
        if (11'(item_index) >= tab[partition_id[PW-1:0]].count)
          acc_status = prc_pkg::ST_VIOLATION;
      end
    end else if (32'(byte_address) >= STORE_BYTES) begin
      acc_status = prc_pkg::ST_VIOLATION;
    end
  end

  always_comb begin
    rd_addr = (state == S_IDLE) ? byte_address[AW-1:0] : a[AW-1:0];
    wr_en = 1'b0;
    wr_addr = dst[AW-1:0];
    wr_data = src_ok ? rd_byte : 8'hFF;
    if (state == S_WR && dst_ok) wr_en = 1'b1;
    if (state == S_BYTE && cmd == prc_pkg::CMD_WRITE && status == prc_pkg::ST_OK) begin
      wr_en = 1'b1;
      wr_addr = baddr[AW-1:0];
      wr_data = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= 11'd1024;
      data_start <= 10'd64;
    end else if (cfg_we) begin
      if (cfg_index == prc_pkg::REG_MEMORY_SIZE) memory_size <= cfg_data;
      else data_start <= cfg_data[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < PARTITIONS; i++) tab[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          cmd <= command; id <= partition_id[PW-1:0];
          nsize <= new_size; ncount <= new_count;
          baddr <= byte_address; wdata <= write_data;
          status <= acc_status; address <= acc_address; read_data <= '0;
          if (command == prc_pkg::CMD_RESIZE || command == prc_pkg::CMD_TRANSLATE) begin
            if (id_bad || command == prc_pkg::CMD_TRANSLATE) begin
              out_valid <= 1'b1;
            end else begin
              old_total <= tab[partition_id[PW-1:0]].size * tab[partition_id[PW-1:0]].count;
              new_total <= new_size * new_count;
              start <= 24'(tab[partition_id[PW-1:0]].start);
              later <= 1'b0;
              scan <= '0;
              state <= S_SCAN;
            end
          end else begin
            state <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (cmd == prc_pkg::CMD_READ && status == prc_pkg::ST_OK) read_data <= rd_byte;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          // lower entries: last active one sets the placement; higher: move window
          if (scan_active) begin
            if (scan[PW-1:0] < id) begin
              if (tab[id].start == 11'd0 && new_total != 23'd0)
                start <= 24'(scan_e.start) + 24'(scan_total);
            end else if (scan[PW-1:0] > id) begin
              if (!later) move_lo <= 24'(scan_e.start);
              later <= 1'b1;
              move_hi <= 24'(scan_e.start) + 24'(scan_total);
            end
          end
          if (32'(scan) == PARTITIONS - 1) state <= S_DECIDE;
          scan <= scan + 1'b1;
        end
        S_DECIDE: begin
          shift <= 26'(new_total) - 26'(old_total);
          if (old_total == new_total) begin
            tab[id].size <= nsize; tab[id].count <= ncount;
            out_valid <= 1'b1; state <= S_IDLE;
          end else begin
            if (start == 24'd0 && new_total != 23'd0) start <= 24'(data_start);
            if (!later) begin
              if ((start == 24'd0 && new_total != 23'd0 ?
                   25'(data_start) : 25'(start)) + 25'(new_total) > 25'(memory_size)) begin
                status <= prc_pkg::ST_FULL; out_valid <= 1'b1; state <= S_IDLE;
              end else begin
                state <= S_FIX;
              end
            end else if (new_total > old_total &&
                26'(move_hi) + 26'(new_total) - 26'(old_total) > 26'(memory_size)) begin
              status <= prc_pkg::ST_FULL; out_valid <= 1'b1; state <= S_IDLE;
            end else begin
              a <= (new_total > old_total) ? 26'(move_hi) - 26'sd1 : 26'(move_lo);
              state <= (move_hi > move_lo) ? S_RD : S_FIX;
            end
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (shift > 0) begin
            a <= a - 26'sd1;
            state <= (a - 26'sd1 >= $signed(26'(move_lo))) ? S_RD : S_FIX;
          end else begin
            a <= a + 26'sd1;
            state <= (a + 26'sd1 < $signed(26'(move_hi))) ? S_RD : S_FIX;
          end
          scan <= '0;
        end
        S_FIX: begin
          for (int i = 0; i < PARTITIONS; i++)
            if (i > 32'(id) && later && tab[i].size != 11'd0 && tab[i].count != 11'd0)
              tab[i].start <= 11'(26'(tab[i].start) + shift);
          tab[id].size <= nsize; tab[id].count <= ncount;
          tab[id].start <= (new_total == 23'd0) ? 11'd0 : start[10:0];
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_wr_only_moving: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_WR || state == S_BYTE)) else $error("stray store write");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status)) else $error("result lost");
endmodule

// ===== rtl/prc_store.sv =====
// byte store with one read and one write port, erased by a clearing pass after reset
module prc_store #(
  parameter int STORE_BYTES = prc_pkg::STORE_BYTES_DEF,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          clearing
);
  logic [7:0] mem [STORE_BYTES];
  logic [AW:0] clr_addr;

  assign clearing = 32'(clr_addr) < STORE_BYTES;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr[AW-1:0]] <= 8'hFF;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
